### rtl/core/gbs_pkg.sv
// Shared types, constants and filter kernels of the blur and gradient magnitude block.
`default_nettype none
package gbs_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIMX_W = COL_W + 1;
    localparam int ROW_W = 16;
    localparam int CFG_WIDTH_W = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int LINE_DEPTH = 8 * MAX_WIDTH;
    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int PIX_W = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int WIN = 7;
    localparam int WIN_W = 3;
    localparam int TAPS = WIN * WIN;
    localparam int TAP_W = $clog2(TAPS);
    localparam int COEF_W = 10;
    localparam int PROD_W = COEF_W + 9;
    localparam int ACC_W = 21;
    localparam int MAG_W = 20;
    localparam int SQ_W = 2 * MAG_W;
    localparam int RAD_W = SQ_W + 2;
    localparam int SQRT_STEPS = MAG_W + 1;
    localparam int ITER_W = $clog2(SQRT_STEPS);
    localparam int DIVISOR = 273;
    localparam int ROOT_W = 19;
    localparam int QUO_W = 11;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W = 20;
    localparam int RECIP_MUL = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_last;
    } pix_out_t;

    typedef struct packed {
        logic [COL_W-1:0]   ox;
        logic [ROW_W-1:0]   oy;
        logic [LINE_AW-1:0] optr;
        logic               last;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        logic [PIX_W-1:0]   data;
    } wr_t;

    typedef struct packed {
        logic [DIMX_W-1:0] w_eff;
        logic [ROW_W-1:0]  h_eff;
    } dims_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_DRAIN,
        BK_SQUARE,
        BK_SUM,
        BK_SQRT,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef logic signed [COEF_W-1:0] coef_table_t [TAPS];

    localparam int GAUSS [5][5] = '{
        '{1, 4, 7, 4, 1},
        '{4, 16, 26, 16, 4},
        '{7, 26, 41, 26, 7},
        '{4, 16, 26, 16, 4},
        '{1, 4, 7, 4, 1}
    };
    localparam int SOBEL_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    localparam int SOBEL_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

    // The Sobel operator convolved with the Gaussian gives one 7x7 kernel per axis.
    function automatic coef_table_t build_kernel(input bit is_y);
        coef_table_t t;
        int acc;
        int ii;
        int jj;
        for (int v = 0; v < WIN; v++) begin
            for (int u = 0; u < WIN; u++) begin
                acc = 0;
                for (int dj = 0; dj < 3; dj++) begin
                    for (int di = 0; di < 3; di++) begin
                        ii = u - di;
                        jj = v - dj;
                        if (ii >= 0 && ii < 5 && jj >= 0 && jj < 5) begin
                            acc = acc + (is_y ? SOBEL_Y[dj][di] : SOBEL_X[dj][di])
                                * GAUSS[jj][ii];
                        end
                    end
                end
                t[v * WIN + u] = COEF_W'(acc);
            end
        end
        return t;
    endfunction

    localparam coef_table_t KERNEL_X = build_kernel(1'b0);
    localparam coef_table_t KERNEL_Y = build_kernel(1'b1);

endpackage
`default_nettype wire

### rtl/core/gbs_queue.sv
// Two-entry job queue between the front and back parts.
`default_nettype none
module gbs_queue
    import gbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    input  wire logic pop,
    output logic      full,
    output logic      valid,
    output job_t      head
);

    job_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/gbs_front.sv
// Front part: configuration, pixel storage writes and output scheduling.
`default_nettype none
module gbs_front
    import gbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire pix_in_t                in_data,
    input  wire logic                   q_full,
    output logic                        in_ready,
    output logic                        push,
    output job_t                        job,
    output wr_t                         wr,
    output dims_t                       dims
);

    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [COL_W-1:0]       in_col_reg;
    logic [COL_W-1:0]       in_col_next;
    logic [ROW_W-1:0]       in_row_reg;
    logic [ROW_W-1:0]       in_row_next;
    logic [COL_W-1:0]       ox_reg;
    logic [ROW_W-1:0]       oy_reg;
    logic [LINE_AW-1:0]     optr_reg;
    logic [LINE_AW-1:0]     wr_ptr_reg;
    logic [LINE_AW-1:0]     wr_ptr_next;
    logic [DIMX_W-1:0]      w_eff;
    logic [ROW_W-1:0]       h_eff;
    logic [DIMX_W-1:0]      w_m1;
    logic [ROW_W-1:0]       h_m1;
    logic [DIMX_W-1:0]      col_inc;
    logic [DIMX_W-1:0]      rx;
    logic [ROW_W:0]         ry;
    logic [DIMX_W-1:0]      ox_plus;
    logic [ROW_W:0]         oy_plus;
    logic                   xfer;
    logic                   pix_ok;
    logic                   ready_out;
    logic                   is_last;
    logic                   cfg_hit;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIMX_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = DIMX_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DIMX_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign w_m1 = w_eff - 1'b1;
    assign h_m1 = h_eff - 1'b1;
    assign dims = '{w_eff: w_eff, h_eff: h_eff};
    assign in_ready = !q_full;
    assign xfer = in_valid && in_ready;
    assign pix_ok = xfer && !in_data.req_type && (in_row_reg < h_eff);
    assign cfg_hit = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_comb
    begin
        col_inc = {1'b0, in_col_reg} + 1'b1;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        wr_ptr_next = wr_ptr_reg;
        if (pix_ok)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
            if (col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = col_inc[COL_W-1:0];
            end
        end
        ox_plus = {1'b0, ox_reg} + DIMX_W'(3);
        oy_plus = {1'b0, oy_reg} + (ROW_W + 1)'(3);
        rx = (ox_plus > w_m1) ? w_m1 : ox_plus;
        ry = (oy_plus > {1'b0, h_m1}) ? {1'b0, h_m1} : oy_plus;
        ready_out = ({1'b0, in_row_next} > ry)
            || (({1'b0, in_row_next} == ry) && ({1'b0, in_col_next} > rx));
        is_last = ({1'b0, ox_reg} == w_m1) && (oy_reg == h_m1);
    end

    assign push = xfer && ready_out;
    assign job = '{ox: ox_reg, oy: oy_reg, optr: optr_reg, last: is_last};
    assign wr = '{en: pix_ok, addr: wr_ptr_reg,
                  data: {in_data.red_in, in_data.green_in, in_data.blue_in}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            in_col_reg <= '0;
            in_row_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            optr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data[CFG_WIDTH_W-1:0];
            end
            else
            begin
                height_reg <= cfg_data[ROW_W-1:0];
            end
            in_col_reg <= '0;
            in_row_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            optr_reg <= wr_ptr_reg;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (push && is_last)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                ox_reg <= '0;
                oy_reg <= '0;
                optr_reg <= wr_ptr_next;
            end
            else
            begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                if (push)
                begin
                    optr_reg <= optr_reg + 1'b1;
                    if ({1'b0, ox_reg} == w_m1)
                    begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + 1'b1;
                    end
                    else
                    begin
                        ox_reg <= ox_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/gbs_back.sv
// Back part: pixel store, 7x7 gradient accumulation, square root and scaling.
`default_nettype none
module gbs_back
    import gbs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire wr_t   wr,
    input  wire dims_t dims,
    input  wire logic  q_valid,
    input  wire job_t  q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pix_out_t   out_data
);

    logic [PIX_W-1:0]          mem [LINE_DEPTH];
    logic [PIX_W-1:0]          rd_data_reg;
    logic [LINE_AW-1:0]        rd_addr;
    back_state_t               state_reg;
    back_state_t               state_next;
    job_t                      job_reg;
    logic [WIN_W-1:0]          cu_reg;
    logic [WIN_W-1:0]          cv_reg;
    logic [TAP_W-1:0]          tap_reg;
    logic [TAP_W-1:0]          tap_d_reg;
    logic                      mac_valid_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [ACC_W-1:0]   acc_x_reg [3];
    logic signed [ACC_W-1:0]   acc_y_reg [3];
    logic [SQ_W-1:0]           sq_a_reg [3];
    logic [SQ_W-1:0]           sq_b_reg [3];
    logic [RAD_W-1:0]          rad_reg [3];
    logic [RAD_W-1:0]          root_reg [3];
    logic [RAD_W-1:0]          bit_reg;
    logic [ROOT_W-1:0]         rem_reg [3];
    logic [QUO_W-1:0]          quo_reg [3];
    logic [ROOT_W+RECIP_W-1:0] quo_prod [3];
    logic [RAD_W-1:0]          rad_nx [3];
    logic [RAD_W-1:0]          root_nx [3];
    logic signed [PROD_W-1:0]  prod_x [3];
    logic signed [PROD_W-1:0]  prod_y [3];
    logic [MAG_W-1:0]          mag_x [3];
    logic [MAG_W-1:0]          mag_y [3];
    logic [7:0]                edge_val [3];
    logic signed [12:0]        tx;
    logic [DIMX_W-1:0]         cx;
    logic signed [12:0]        dx;
    logic signed [ROW_W+1:0]   ty;
    logic [ROW_W-1:0]          cy;
    logic signed [ROW_W+1:0]   dy;
    logic signed [16:0]        offset;
    logic [7:0]                smp;
    logic signed [ACC_W-1:0]   abs_x;
    logic signed [ACC_W-1:0]   abs_y;

    // Window tap address, with the coordinates held to the frame edges.
    always_comb
    begin
        tx = $signed({2'b00, job_reg.ox}) + $signed({10'b0, cu_reg}) - 13'sd3;
        if (tx < 0)
        begin
            cx = '0;
        end
        else if (tx > $signed({1'b0, dims.w_eff - 1'b1}))
        begin
            cx = dims.w_eff - 1'b1;
        end
        else
        begin
            cx = tx[DIMX_W-1:0];
        end
        dx = $signed({1'b0, cx}) - $signed({2'b00, job_reg.ox});
        ty = $signed({2'b00, job_reg.oy}) + $signed({15'b0, cv_reg}) - 18'sd3;
        if (ty < 0)
        begin
            cy = '0;
        end
        else if (ty > $signed({2'b00, dims.h_eff - 1'b1}))
        begin
            cy = dims.h_eff - 1'b1;
        end
        else
        begin
            cy = ty[ROW_W-1:0];
        end
        dy = $signed({2'b00, cy}) - $signed({2'b00, job_reg.oy});
        offset = $signed(dy[3:0]) * $signed({1'b0, dims.w_eff}) + 17'(dx);
        rd_addr = job_reg.optr + offset[LINE_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            smp = rd_data_reg[PIX_W - 1 - 8 * c -: 8];
            prod_x[c] = KERNEL_X[tap_d_reg] * $signed({1'b0, smp});
            prod_y[c] = KERNEL_Y[tap_d_reg] * $signed({1'b0, smp});
            abs_x = acc_x_reg[c][ACC_W-1] ? -acc_x_reg[c] : acc_x_reg[c];
            abs_y = acc_y_reg[c][ACC_W-1] ? -acc_y_reg[c] : acc_y_reg[c];
            mag_x[c] = abs_x[MAG_W-1:0];
            mag_y[c] = abs_y[MAG_W-1:0];
            if (rad_reg[c] >= root_reg[c] + bit_reg)
            begin
                rad_nx[c] = rad_reg[c] - (root_reg[c] + bit_reg);
                root_nx[c] = (root_reg[c] >> 1) + bit_reg;
            end
            else
            begin
                rad_nx[c] = rad_reg[c];
                root_nx[c] = root_reg[c] >> 1;
            end
            // The reciprocal product is exact for every root that fits in ROOT_W bits.
            quo_prod[c] = {{RECIP_W{1'b0}}, rem_reg[c]} * (ROOT_W + RECIP_W)'(RECIP_MUL);
            edge_val[c] = (quo_reg[c] > QUO_W'(255)) ? 8'hFF : quo_reg[c][7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (tap_reg == TAP_W'(TAPS - 1))
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:  state_next = BK_SQUARE;
            BK_SQUARE: state_next = BK_SUM;
            BK_SUM:    state_next = BK_SQRT;
            BK_SQRT:
            begin
                if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:    state_next = BK_OUT;
            BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == BK_IDLE) && q_valid;
        out_valid = (state_reg == BK_OUT);
        out_data = '{red_edge: edge_val[0], green_edge: edge_val[1],
                     blue_edge: edge_val[2], frame_last: job_reg.last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            mac_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mac_valid_reg <= (state_reg == BK_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        tap_d_reg <= tap_reg;
        if (mac_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_x_reg[c] <= acc_x_reg[c]
                    + {{(ACC_W - PROD_W){prod_x[c][PROD_W-1]}}, prod_x[c]};
                acc_y_reg[c] <= acc_y_reg[c]
                    + {{(ACC_W - PROD_W){prod_y[c][PROD_W-1]}}, prod_y[c]};
            end
        end
        case (state_reg)
            BK_IDLE:
            begin
                job_reg <= q_head;
                cu_reg <= '0;
                cv_reg <= '0;
                tap_reg <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    acc_x_reg[c] <= '0;
                    acc_y_reg[c] <= '0;
                end
            end
            BK_READ:
            begin
                tap_reg <= tap_reg + 1'b1;
                if (cu_reg == WIN_W'(WIN - 1))
                begin
                    cu_reg <= '0;
                    cv_reg <= cv_reg + 1'b1;
                end
                else
                begin
                    cu_reg <= cu_reg + 1'b1;
                end
            end
            BK_SQUARE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sq_a_reg[c] <= mag_x[c] * mag_x[c];
                    sq_b_reg[c] <= mag_y[c] * mag_y[c];
                end
            end
            BK_SUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rad_reg[c] <= {2'b00, sq_a_reg[c]} + {2'b00, sq_b_reg[c]};
                    root_reg[c] <= '0;
                end
                bit_reg <= RAD_W'(1) << (2 * (SQRT_STEPS - 1));
                iter_reg <= '0;
            end
            BK_SQRT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rad_reg[c] <= rad_nx[c];
                    root_reg[c] <= root_nx[c];
                    rem_reg[c] <= root_nx[c][ROOT_W-1:0];
                end
                bit_reg <= bit_reg >> 2;
                if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                begin
                    iter_reg <= '0;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
            BK_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    quo_reg[c] <= quo_prod[c][RECIP_SHIFT +: QUO_W];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/gaussian_blur_sobel_magnitude.sv
// Top level of the 5x5 Gaussian blur and 3x3 Sobel gradient magnitude block.
// Pixels enter in raster order and results leave in raster order, one result per
// item once every pixel it depends on has arrived; flush items drain the last rows.
// The front part stores each pixel and schedules outputs, and hands them through a
// two-entry queue to the back part, so input keeps flowing while the queue has room.
// In the back part each result goes through these states in order: taking the job,
// reading the 49 window taps through the single read port of the pixel store and
// draining the read, a square and a sum, 21 square-root steps, one reciprocal
// multiply for the scaling, and the output, which waits for out_ready. The back
// part takes a new item only once it is through with the last one. The pixel
// store needs no clearing pass after reset.
`default_nettype none
module gaussian_blur_sobel_magnitude
    import gbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire pix_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output pix_out_t                    out_data
);

    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;
    job_t  job;
    job_t  q_head;
    wr_t   wr;
    dims_t dims;

    gbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_full),
        .in_ready  (in_ready),
        .push      (push),
        .job       (job),
        .wr        (wr),
        .dims      (dims)
    );

    gbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    gbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .dims      (dims),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
